>>> rtl/core/hwba_pkg.sv
package hwba_pkg;

  localparam int unsigned HEAP_WORDS_DEFAULT = 1024;
  localparam logic [31:0] HEAP_BASE_RESET    = 32'h0000_4000;
  localparam int unsigned NEED_W             = 15;
  localparam int unsigned FREED_W            = 10;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_REQ  = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BAD_PTR  = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] byte_size;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        address_out;
    logic [FREED_W-1:0] freed_words;
  } rsp_t;

  // one heap word: free flag and live-pointer flag
  typedef struct packed {
    logic free;
    logic valid;
  } map_t;

endpackage

>>> rtl/core/heap_word_bitmap_allocator.sv
// channel   | signals                 | transaction
// ----------+-------------------------+--------------------------------------
// request   | start, busy, req        | taken when start is high, busy low
// result    | done, rsp               | done high one cycle, always taken
// config    | cfg_we, cfg_data        | base address written when cfg_we high
//
// after reset a clearing pass walks the map with busy high.
// allocate: a scan reads one map word per cycle from the map ram,
// then each word of the chunk is marked in turn.
// free: S_FCALC and S_FREAD check and read, then each word released is marked free.
// zero-byte allocate answers in the cycle after it is taken.
// the result appears for one cycle; the receiver cannot stall it.
module heap_word_bitmap_allocator #(
  parameter int unsigned HEAP_WORDS = hwba_pkg::HEAP_WORDS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  hwba_pkg::req_t req,
  output logic           done,
  output hwba_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data
);

  import hwba_pkg::*;

  localparam int unsigned AW = $clog2(HEAP_WORDS);
  localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_WORDS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FCALC, S_FREAD, S_FRUN
  } state_t;

  state_t             state;
  logic [31:0]        base;
  logic [AW-1:0]      cnt;
  logic [AW:0]        run;
  logic [NEED_W-1:0]  need;
  logic [31:0]        ptr;
  logic               rd_vld;
  logic               rd_last;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      first;
  logic [AW-1:0]      last;

  logic               map_we;
  logic [AW-1:0]      map_raddr;
  map_t               map_wdata;
  map_t               map_q;
  logic               size_we;
  logic [AW-1:0]      size_raddr;
  logic [AW-1:0]      size_wdata;
  logic [AW-1:0]      size_q;

  logic [16:0]        need_sum;
  logic [AW:0]        run_inc;
  logic               hit;
  logic [AW-1:0]      hit_start;
  logic [31:0]        diff;
  logic [AW-1:0]      fidx;
  logic               ptr_bad;
  logic [AW:0]        fend;
  logic [AW-1:0]      first_p1;

  hwba_ram #(.WIDTH(2), .DEPTH(HEAP_WORDS)) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (cnt),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  hwba_ram #(.WIDTH(AW), .DEPTH(HEAP_WORDS)) u_size (
    .clk   (clk),
    .we    (size_we),
    .waddr (first),
    .wdata (size_wdata),
    .raddr (size_raddr),
    .rdata (size_q)
  );

  assign busy = (state != S_IDLE);

  assign need_sum = {1'b0, req.byte_size} + 17'd3;

  // run counter counts consecutive free words during the scan
  assign run_inc   = run + 1'b1;
  assign hit       = rd_vld && map_q.free && (32'(run_inc) == 32'(need));
  assign hit_start = rd_idx + 1'b1 - AW'(need);

  assign diff    = ptr - base;
  assign fidx    = diff[AW+1:2];
  assign ptr_bad = (ptr == 32'd0) || diff[31] || (diff[31:2] >= 30'(HEAP_WORDS))
                   || (fidx == '0);

  // last word released; clipped to the end of the heap when loaded into last
  assign fend     = {1'b0, first} + {1'b0, size_q};
  assign first_p1 = first + 1'b1;

  assign size_we    = (state == S_MARK);
  assign size_wdata = AW'(need - 1'b1);
  assign size_raddr = fidx - 1'b1;

  always_comb begin
    map_we    = 1'b0;
    map_wdata = '{free: 1'b1, valid: 1'b0};
    map_raddr = cnt;
    unique case (state)
      S_CLEAR: map_we = 1'b1;
      S_MARK: begin
        map_we    = 1'b1;
        map_wdata = '{free: 1'b0, valid: (cnt == first_p1)};
      end
      S_FRUN:  map_we = 1'b1;
      S_FCALC: map_raddr = fidx;
      default: map_raddr = cnt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      base    <= HEAP_BASE_RESET;
      cnt     <= '0;
      run     <= '0;
      rd_vld  <= 1'b0;
      rd_last <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        base <= cfg_data;
      end
      unique case (state)
        S_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            ptr     <= req.address;
            need    <= NEED_W'(need_sum[16:2]) + 1'b1;
            cnt     <= '0;
            run     <= '0;
            rd_vld  <= 1'b0;
            rd_last <= 1'b0;
            if (req.req_type == REQ_FREE) begin
              state <= S_FCALC;
            end else if (req.byte_size == 16'd0) begin
              done            <= 1'b1;
              rsp.status      <= ST_BAD_REQ;
              rsp.address_out <= '0;
              rsp.freed_words <= '0;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // read issued this cycle, previous read checked
          cnt     <= cnt + 1'b1;
          rd_vld  <= 1'b1;
          rd_idx  <= cnt;
          rd_last <= (cnt == LAST_IDX);
          if (rd_vld) begin
            run <= map_q.free ? run_inc : '0;
          end
          if (hit) begin
            first <= hit_start;
            last  <= rd_idx;
            cnt   <= hit_start;
            state <= S_MARK;
          end else if (rd_vld && rd_last) begin
            done            <= 1'b1;
            rsp.status      <= ST_NO_SPACE;
            rsp.address_out <= '0;
            rsp.freed_words <= '0;
            state           <= S_IDLE;
          end
        end
        S_MARK: begin
          cnt <= cnt + 1'b1;
          if (cnt == last) begin
            done            <= 1'b1;
            rsp.status      <= ST_OK;
            rsp.address_out <= base + {{(30 - AW){1'b0}}, first_p1, 2'b00};
            rsp.freed_words <= '0;
            state           <= S_IDLE;
          end
        end
        S_FCALC: begin
          first <= fidx - 1'b1;
          if (ptr_bad) begin
            done            <= 1'b1;
            rsp.status      <= ST_BAD_PTR;
            rsp.address_out <= '0;
            rsp.freed_words <= '0;
            state           <= S_IDLE;
          end else begin
            state <= S_FREAD;
          end
        end
        S_FREAD: begin
          cnt <= first;
          if (!map_q.valid) begin
            done            <= 1'b1;
            rsp.status      <= ST_BAD_PTR;
            rsp.address_out <= '0;
            rsp.freed_words <= '0;
            state           <= S_IDLE;
          end else begin
            last            <= (fend > {1'b0, LAST_IDX}) ? LAST_IDX : fend[AW-1:0];
            rsp.freed_words <= FREED_W'(size_q);
            state           <= S_FRUN;
          end
        end
        S_FRUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == last) begin
            done            <= 1'b1;
            rsp.status      <= ST_OK;
            rsp.address_out <= '0;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/core/hwba_ram.sv
module hwba_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
